FILE: src/pth_sensor_compensation_unit_assert.svh
// Assertion macros for the sensor compensation unit checker.
// Needs nothing else; included by the checker file.
`ifndef PTH_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define PTH_SENSOR_COMPENSATION_UNIT_ASSERT_SVH

// same-cycle implication
`define PSCU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSCU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/pscu_pkg.sv
// Shared types, constants and helpers of the sensor compensation unit.
// No dependencies; imported by every module of the block.
package pscu_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAL_TEMPERATURE   = 3'd0,
      CSR_CAL_PRESSURE_LOW  = 3'd1,
      CSR_CAL_PRESSURE_HIGH = 3'd2,
      CSR_CAL_PRESS_HUM     = 3'd3,
      CSR_CAL_HUMIDITY      = 3'd4,
      CSR_FINE_TEMP_OFFSET  = 3'd5
   } pscu_csr_type;

   // pressure status codes
   localparam logic [1:0] PRESS_OK       = 2'd0;
   localparam logic [1:0] PRESS_DISABLED = 2'd1;
   localparam logic [1:0] PRESS_ZERO_DIV = 2'd2;

   localparam logic [23:0] DISABLED_24   = 24'h800000;
   localparam logic [15:0] DISABLED_16   = 16'h8000;
   localparam logic signed [63:0] PRESS_TF_BIAS = 64'sd128000;
   localparam logic signed [63:0] HUM_TF_BIAS   = 64'sd76800;
   localparam logic signed [63:0] PRESS_P_BASE  = 64'sd1048576;
   localparam logic signed [63:0] PRESS_SCALE   = 64'sd3125;
   localparam logic signed [63:0] HUM_V_MAX     = 64'sd419430400;
   localparam logic signed [63:0] HUM_B_BIAS    = 64'sd2097152;
   localparam logic signed [63:0] HUM_A_ROUND   = 64'sd16384;
   localparam logic signed [63:0] HUM_C_BIAS    = 64'sd32768;
   localparam logic signed [63:0] HUM_B_ROUND   = 64'sd8192;
   localparam logic signed [63:0] TEMP_ROUND    = 64'sd128;
   localparam logic signed [63:0] TEMP_MAX      = 64'sd32767;
   localparam logic signed [63:0] TEMP_MIN      = -64'sd32768;
   localparam logic [16:0] HUM_Q10_MAX = 17'd102400;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE, ST_T_A, ST_T_B, ST_T_C, ST_T_D, ST_T_E,
      ST_P_ENT, ST_P_SQ, ST_P_V2, ST_P_X, ST_P_P4, ST_P_Y, ST_P_Z, ST_P_1,
      ST_P_CHK, ST_P_N, ST_P_DIV, ST_P_Q1, ST_P_Q2, ST_P_Q3, ST_P_SUM, ST_P_FIN,
      ST_H_ENT, ST_H_A, ST_H_B1, ST_H_B2, ST_H_C, ST_H_D, ST_H_E, ST_H_F,
      ST_H_G, ST_H_H, ST_H_I, ST_H_J, ST_H_K, ST_OUT
   } pscu_state_type;

   // operation request/response to the serial arithmetic units
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } pscu_op_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } pscu_op_rsp_type;

   function automatic logic signed [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic signed [63:0] sext21(input logic [20:0] v);
      return {{43{v[20]}}, v};
   endfunction

   function automatic logic signed [63:0] sext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic signed [63:0] sext12(input logic [11:0] v);
      return {{52{v[11]}}, v};
   endfunction

   function automatic logic signed [63:0] sext8(input logic [7:0] v);
      return {{56{v[7]}}, v};
   endfunction

endpackage

FILE: src/pscu_ifs.sv
// Request and response channel interfaces of the sensor compensation unit.
// No dependencies.
interface pscu_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] raw_temperature;
   logic [23:0] raw_pressure;
   logic [15:0] raw_humidity;

   modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
   modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface pscu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] temp_centi;
   logic               temp_valid;
   logic [31:0]        press_q8;
   logic [1:0]         press_status;
   logic [16:0]        hum_q10;
   logic               hum_valid;

   modport source (output valid, temp_centi, temp_valid, press_q8, press_status, hum_q10,
                   hum_valid, input ready);
   modport sink (input valid, temp_centi, temp_valid, press_q8, press_status, hum_q10,
                 hum_valid, output ready);
endinterface

FILE: src/pscu_mul.sv
// Bit-serial 64-bit multiplier (low 64 bits of the product, wrapping).
// Depends on pscu_pkg.
module pscu_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  pscu_pkg::pscu_op_req_type op_req,
   output pscu_pkg::pscu_op_rsp_type op_rsp
);
   import pscu_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] mcand_ff, mcand_in;
   logic [63:0] mplier_ff, mplier_in;
   logic [63:0] result_ff, result_in;

   // one multiplier bit per cycle, magnitude of b; stops when it runs out
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      result_in = result_ff;
      if (op_req.start) begin
         busy_in   = 1'b1;
         acc_in    = '0;
         mcand_in  = op_req.a;
         mplier_in = op_req.b[63] ? (~op_req.b + 64'd1) : op_req.b;
         neg_in    = op_req.b[63];
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = neg_ff ? (~acc_ff + 64'd1) : acc_ff;
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[62:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[63:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      result_ff <= result_in;
   end

   assign op_rsp.done   = done_ff;
   assign op_rsp.result = result_ff;

endmodule

FILE: src/pscu_div.sv
// Bit-serial signed 64-bit divider, quotient truncated toward zero.
// Depends on pscu_pkg.
module pscu_div (
   input  logic                      clock,
   input  logic                      reset,
   input  pscu_pkg::pscu_op_req_type op_req,
   output pscu_pkg::pscu_op_rsp_type op_rsp
);
   import pscu_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        qneg_ff, qneg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dabs_ff, dabs_in;
   logic [63:0] result_ff, result_in;
   logic [64:0] shifted;
   logic [64:0] trial;

   assign shifted = {rem_ff, quo_ff[63]};
   assign trial   = shifted - {1'b0, dabs_ff};

   // restoring division on magnitudes, one quotient bit per cycle
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      qneg_in   = qneg_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dabs_in   = dabs_ff;
      result_in = result_ff;
      if (op_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd64;
         rem_in  = '0;
         quo_in  = op_req.a[63] ? (~op_req.a + 64'd1) : op_req.a;
         dabs_in = op_req.b[63] ? (~op_req.b + 64'd1) : op_req.b;
         qneg_in = op_req.a[63] ^ op_req.b[63];
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = qneg_ff ? (~quo_ff + 64'd1) : quo_ff;
         end else begin
            cnt_in = cnt_ff - 7'd1;
            if (!trial[64]) begin
               rem_in = trial[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = shifted[63:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      qneg_ff   <= qneg_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dabs_ff   <= dabs_in;
      result_ff <= result_in;
   end

   assign op_rsp.done   = done_ff;
   assign op_rsp.result = result_ff;

endmodule

FILE: src/pth_sensor_compensation_unit.sv
// Each sample set runs through up to 21 bit-serial multiplies and one bit-serial divide, one at a time;
// a multiply ends once no set bits are left in its multiplier magnitude.
// A new sample set is taken only once the last has reached the response register, also while that result waits.
// Reset (synchronous, active high) clears calibration, fine temperature and control state.
// Depends on pscu_pkg, pscu_ifs, pscu_mul, pscu_div.
module pth_sensor_compensation_unit (
   input  logic                                clock,
   input  logic                                reset,
   pscu_req_if.sink                            req_bus,
   pscu_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [pscu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pscu_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pscu_pkg::*;

   pscu_state_type state_ff, state_in;

   // calibration registers
   logic [47:0] cal_t_ff;
   logic [63:0] cal_pl_ff;
   logic [63:0] cal_ph_ff;
   logic [47:0] cal_phum_ff;
   logic [31:0] cal_h_ff;
   logic [20:0] off_ff;

   // sample and working registers
   logic [23:0] rt_ff, rt_in;
   logic [23:0] rp_ff, rp_in;
   logic [15:0] rh_ff, rh_in;
   logic signed [31:0] lft_ff, lft_in;
   logic signed [63:0] x_ff, x_in, y_ff, y_in, z_ff, z_in, w_ff, w_in;
   logic        issued_ff, issued_in;

   // working results and response register
   logic signed [15:0] tc_ff, tc_in;
   logic        tv_ff, tv_in;
   logic [31:0] pq_ff, pq_in;
   logic [1:0]  ps_ff, ps_in;
   logic [16:0] hq_ff, hq_in;
   logic        hv_ff, hv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] o_tc_ff;
   logic        o_tv_ff;
   logic [31:0] o_pq_ff;
   logic [1:0]  o_ps_ff;
   logic [16:0] o_hq_ff;
   logic        o_hv_ff;

   pscu_op_req_type mul_req, div_req;
   pscu_op_rsp_type mul_rsp, div_rsp;

   logic accept;
   logic out_load;
   logic signed [63:0] prod, quot;
   logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [63:0] h1, h2, h3, h4, h5, h6;
   logic signed [63:0] lft64, pv, hvar, pp, tsum, psum, hsum;

   pscu_mul u_mul (.clock(clock), .reset(reset), .op_req(mul_req), .op_rsp(mul_rsp));
   pscu_div u_div (.clock(clock), .reset(reset), .op_req(div_req), .op_rsp(div_rsp));

   assign prod = mul_rsp.result;
   assign quot = div_rsp.result;

   // coefficient fields
   assign t1 = {48'd0, cal_t_ff[15:0]};
   assign t2 = sext16(cal_t_ff[31:16]);
   assign t3 = sext16(cal_t_ff[47:32]);
   assign p1 = {48'd0, cal_pl_ff[15:0]};
   assign p2 = sext16(cal_pl_ff[31:16]);
   assign p3 = sext16(cal_pl_ff[47:32]);
   assign p4 = sext16(cal_pl_ff[63:48]);
   assign p5 = sext16(cal_ph_ff[15:0]);
   assign p6 = sext16(cal_ph_ff[31:16]);
   assign p7 = sext16(cal_ph_ff[47:32]);
   assign p8 = sext16(cal_ph_ff[63:48]);
   assign p9 = sext16(cal_phum_ff[15:0]);
   assign h1 = {56'd0, cal_phum_ff[23:16]};
   assign h2 = sext16(cal_phum_ff[39:24]);
   assign h3 = {56'd0, cal_phum_ff[47:40]};
   assign h4 = sext12(cal_h_ff[11:0]);
   assign h5 = sext12(cal_h_ff[23:12]);
   assign h6 = sext8(cal_h_ff[31:24]);

   // derived terms
   assign lft64 = sext32(lft_ff);
   assign pv    = lft64 - PRESS_TF_BIAS;
   assign hsum  = lft64 - HUM_TF_BIAS;
   assign hvar  = sext32(hsum[31:0]);
   assign pp    = PRESS_P_BASE - {44'd0, rp_ff[23:4]};
   assign tsum  = ((lft64 <<< 2) + lft64 + TEMP_ROUND) >>> 8;
   assign psum  = (w_ff >>> 8) + (p7 <<< 4);

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t_ff    <= '0;
         cal_pl_ff   <= '0;
         cal_ph_ff   <= '0;
         cal_phum_ff <= '0;
         cal_h_ff    <= '0;
         off_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAL_TEMPERATURE:   cal_t_ff    <= csr_wdata[47:0];
            CSR_CAL_PRESSURE_LOW:  cal_pl_ff   <= csr_wdata;
            CSR_CAL_PRESSURE_HIGH: cal_ph_ff   <= csr_wdata;
            CSR_CAL_PRESS_HUM:     cal_phum_ff <= csr_wdata[47:0];
            CSR_CAL_HUMIDITY:      cal_h_ff    <= csr_wdata[31:0];
            CSR_FINE_TEMP_OFFSET:  off_ff      <= csr_wdata[20:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_bus.raw_temperature != DISABLED_24) ? ST_T_A : ST_P_ENT;
            end
         end
         ST_T_A:   if (mul_rsp.done) state_in = ST_T_B;
         ST_T_B:   if (mul_rsp.done) state_in = ST_T_C;
         ST_T_C:   if (mul_rsp.done) state_in = ST_T_D;
         ST_T_D:   state_in = ST_T_E;
         ST_T_E:   state_in = ST_P_ENT;
         ST_P_ENT: state_in = (rp_ff == DISABLED_24) ? ST_H_ENT : ST_P_SQ;
         ST_P_SQ:  if (mul_rsp.done) state_in = ST_P_V2;
         ST_P_V2:  if (mul_rsp.done) state_in = ST_P_X;
         ST_P_X:   if (mul_rsp.done) state_in = ST_P_P4;
         ST_P_P4:  state_in = ST_P_Y;
         ST_P_Y:   if (mul_rsp.done) state_in = ST_P_Z;
         ST_P_Z:   if (mul_rsp.done) state_in = ST_P_1;
         ST_P_1:   if (mul_rsp.done) state_in = ST_P_CHK;
         ST_P_CHK: state_in = (x_ff == '0) ? ST_H_ENT : ST_P_N;
         ST_P_N:   if (mul_rsp.done) state_in = ST_P_DIV;
         ST_P_DIV: if (div_rsp.done) state_in = ST_P_Q1;
         ST_P_Q1:  if (mul_rsp.done) state_in = ST_P_Q2;
         ST_P_Q2:  if (mul_rsp.done) state_in = ST_P_Q3;
         ST_P_Q3:  if (mul_rsp.done) state_in = ST_P_SUM;
         ST_P_SUM: state_in = ST_P_FIN;
         ST_P_FIN: state_in = ST_H_ENT;
         ST_H_ENT: state_in = (rh_ff == DISABLED_16) ? ST_OUT : ST_H_A;
         ST_H_A:   if (mul_rsp.done) state_in = ST_H_B1;
         ST_H_B1:  state_in = ST_H_B2;
         ST_H_B2:  state_in = ST_H_C;
         ST_H_C:   if (mul_rsp.done) state_in = ST_H_D;
         ST_H_D:   if (mul_rsp.done) state_in = ST_H_E;
         ST_H_E:   if (mul_rsp.done) state_in = ST_H_F;
         ST_H_F:   state_in = ST_H_G;
         ST_H_G:   if (mul_rsp.done) state_in = ST_H_H;
         ST_H_H:   if (mul_rsp.done) state_in = ST_H_I;
         ST_H_I:   if (mul_rsp.done) state_in = ST_H_J;
         ST_H_J:   if (mul_rsp.done) state_in = ST_H_K;
         ST_H_K:   state_in = ST_OUT;
         ST_OUT:   if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs: handshake and operand selection
   always_comb begin
      mul_req       = '0;
      div_req       = '0;
      req_bus.ready = 1'b0;
      case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_T_A: begin
            mul_req.a = {47'd0, rt_ff[23:7]} - (t1 <<< 1);
            mul_req.b = t2;
         end
         ST_T_B: begin
            mul_req.a = {48'd0, rt_ff[23:8]} - t1;
            mul_req.b = {48'd0, rt_ff[23:8]} - t1;
         end
         ST_T_C: begin
            mul_req.a = y_ff >>> 12;
            mul_req.b = t3;
         end
         ST_P_SQ: begin
            mul_req.a = pv;
            mul_req.b = pv;
         end
         ST_P_V2: begin
            mul_req.a = x_ff;
            mul_req.b = p6;
         end
         ST_P_X: begin
            mul_req.a = pv;
            mul_req.b = p5;
         end
         ST_P_Y: begin
            mul_req.a = x_ff;
            mul_req.b = p3;
         end
         ST_P_Z: begin
            mul_req.a = pv;
            mul_req.b = p2;
         end
         ST_P_1: begin
            mul_req.a = (64'sd1 <<< 47) + z_ff;
            mul_req.b = p1;
         end
         ST_P_N: begin
            mul_req.a = (pp <<< 31) - y_ff;
            mul_req.b = PRESS_SCALE;
         end
         ST_P_DIV: begin
            div_req.a = z_ff;
            div_req.b = x_ff;
         end
         ST_P_Q1: begin
            mul_req.a = w_ff >>> 13;
            mul_req.b = p9;
         end
         ST_P_Q2: begin
            mul_req.a = w_ff >>> 13;
            mul_req.b = x_ff;
         end
         ST_P_Q3: begin
            mul_req.a = w_ff;
            mul_req.b = p8;
         end
         ST_H_A: begin
            mul_req.a = hvar;
            mul_req.b = h5;
         end
         ST_H_C: begin
            mul_req.a = hvar;
            mul_req.b = h6;
         end
         ST_H_D: begin
            mul_req.a = hvar;
            mul_req.b = h3;
         end
         ST_H_E: begin
            mul_req.a = y_ff;
            mul_req.b = z_ff;
         end
         ST_H_G: begin
            mul_req.a = y_ff;
            mul_req.b = h2;
         end
         ST_H_H: begin
            mul_req.a = x_ff;
            mul_req.b = y_ff;
         end
         ST_H_I: begin
            mul_req.a = w_ff >>> 15;
            mul_req.b = w_ff >>> 15;
         end
         ST_H_J: begin
            mul_req.a = z_ff;
            mul_req.b = h1;
         end
         default: ;
      endcase
      // launch once per step
      case (state_ff)
         ST_T_A, ST_T_B, ST_T_C, ST_P_SQ, ST_P_V2, ST_P_X, ST_P_Y, ST_P_Z, ST_P_1,
         ST_P_N, ST_P_Q1, ST_P_Q2, ST_P_Q3, ST_H_A, ST_H_C, ST_H_D, ST_H_E, ST_H_G,
         ST_H_H, ST_H_I, ST_H_J: mul_req.start = !issued_ff;
         ST_P_DIV: div_req.start = !issued_ff;
         default: ;
      endcase
   end

   // datapath updates
   always_comb begin
      rt_in  = rt_ff;
      rp_in  = rp_ff;
      rh_in  = rh_ff;
      lft_in = lft_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      w_in   = w_ff;
      tc_in  = tc_ff;
      tv_in  = tv_ff;
      pq_in  = pq_ff;
      ps_in  = ps_ff;
      hq_in  = hq_ff;
      hv_in  = hv_ff;
      issued_in = issued_ff;
      if (mul_req.start || div_req.start) begin
         issued_in = 1'b1;
      end else if (mul_rsp.done || div_rsp.done) begin
         issued_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rt_in = req_bus.raw_temperature;
               rp_in = req_bus.raw_pressure;
               rh_in = req_bus.raw_humidity;
               tc_in = '0;
               tv_in = 1'b0;
               pq_in = '0;
               ps_in = PRESS_DISABLED;
               hq_in = '0;
               hv_in = 1'b0;
            end
         end
         ST_T_A: if (mul_rsp.done) x_in = prod;
         ST_T_B: if (mul_rsp.done) y_in = prod;
         ST_T_C: if (mul_rsp.done) z_in = prod >>> 14;
         ST_T_D: begin
            w_in   = (x_ff >>> 11) + z_ff + sext21(off_ff);
            lft_in = w_in[31:0];
         end
         ST_T_E: begin
            tv_in = 1'b1;
            if (tsum > TEMP_MAX) begin
               tc_in = TEMP_MAX[15:0];
            end else if (tsum < TEMP_MIN) begin
               tc_in = TEMP_MIN[15:0];
            end else begin
               tc_in = tsum[15:0];
            end
         end
         ST_P_SQ:  if (mul_rsp.done) x_in = prod;
         ST_P_V2:  if (mul_rsp.done) y_in = prod;
         ST_P_X:   if (mul_rsp.done) y_in = y_ff + (prod <<< 17);
         ST_P_P4:  y_in = y_ff + (p4 <<< 35);
         ST_P_Y:   if (mul_rsp.done) z_in = prod >>> 8;
         ST_P_Z:   if (mul_rsp.done) z_in = z_ff + (prod <<< 12);
         ST_P_1:   if (mul_rsp.done) x_in = prod >>> 33;
         ST_P_CHK: begin
            if (x_ff == '0) begin
               pq_in = '0;
               ps_in = PRESS_ZERO_DIV;
            end
         end
         ST_P_N:   if (mul_rsp.done) z_in = prod;
         ST_P_DIV: if (div_rsp.done) w_in = quot;
         ST_P_Q1:  if (mul_rsp.done) x_in = prod;
         ST_P_Q2:  if (mul_rsp.done) x_in = prod >>> 25;
         ST_P_Q3:  if (mul_rsp.done) y_in = prod >>> 19;
         ST_P_SUM: w_in = w_ff + x_ff + y_ff;
         ST_P_FIN: begin
            ps_in = PRESS_OK;
            if (psum[63]) begin
               pq_in = '0;
            end else if (psum[62:32] != '0) begin
               pq_in = '1;
            end else begin
               pq_in = psum[31:0];
            end
         end
         ST_H_A:  if (mul_rsp.done) x_in = sext32(prod[31:0]);
         ST_H_B1: begin
            w_in = ({48'd0, rh_ff} <<< 14) - (h4 <<< 20) - x_ff;
            x_in = sext32(w_in[31:0]);
         end
         ST_H_B2: begin
            w_in = x_ff + HUM_A_ROUND;
            x_in = sext32(w_in[31:0]) >>> 15;
         end
         ST_H_C:  if (mul_rsp.done) y_in = sext32(prod[31:0]) >>> 10;
         ST_H_D: begin
            if (mul_rsp.done) begin
               w_in = (sext32(prod[31:0]) >>> 11) + HUM_C_BIAS;
               z_in = sext32(w_in[31:0]);
            end
         end
         ST_H_E:  if (mul_rsp.done) y_in = sext32(prod[31:0]) >>> 10;
         ST_H_F: begin
            w_in = y_ff + HUM_B_BIAS;
            y_in = sext32(w_in[31:0]);
         end
         ST_H_G: begin
            if (mul_rsp.done) begin
               w_in = prod + HUM_B_ROUND;
               y_in = sext32(w_in[31:0]) >>> 14;
            end
         end
         ST_H_H:  if (mul_rsp.done) w_in = sext32(prod[31:0]);
         ST_H_I:  if (mul_rsp.done) z_in = sext32(prod[31:0]) >>> 7;
         ST_H_J:  if (mul_rsp.done) z_in = sext32(prod[31:0]) >>> 4;
         ST_H_K: begin
            w_in  = w_ff - z_ff;
            x_in  = sext32(w_in[31:0]);
            hv_in = 1'b1;
            if (x_in < 0) begin
               hq_in = '0;
            end else if (x_in > HUM_V_MAX) begin
               hq_in = HUM_Q10_MAX;
            end else begin
               hq_in = x_in[28:12];
            end
         end
         default: ;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         lft_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         lft_ff       <= lft_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rt_ff <= rt_in;
      rp_ff <= rp_in;
      rh_ff <= rh_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      z_ff  <= z_in;
      w_ff  <= w_in;
      tc_ff <= tc_in;
      tv_ff <= tv_in;
      pq_ff <= pq_in;
      ps_ff <= ps_in;
      hq_ff <= hq_in;
      hv_ff <= hv_in;
      if (out_load) begin
         o_tc_ff <= tc_ff;
         o_tv_ff <= tv_ff;
         o_pq_ff <= pq_ff;
         o_ps_ff <= ps_ff;
         o_hq_ff <= hq_ff;
         o_hv_ff <= hv_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.temp_centi   = o_tc_ff;
   assign rsp_bus.temp_valid   = o_tv_ff;
   assign rsp_bus.press_q8     = o_pq_ff;
   assign rsp_bus.press_status = o_ps_ff;
   assign rsp_bus.hum_q10      = o_hq_ff;
   assign rsp_bus.hum_valid    = o_hv_ff;

endmodule

FILE: src/pscu_checker.sv
// Port-level checker for the sensor compensation unit, bound to the top level.
// Depends on pscu_pkg and pth_sensor_compensation_unit_assert.svh.
`include "pth_sensor_compensation_unit_assert.svh"

module pscu_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [15:0] temp_centi,
   input logic              temp_valid,
   input logic [31:0]       press_q8,
   input logic [1:0]        press_status,
   input logic [16:0]       hum_q10,
   input logic              hum_valid
);
   import pscu_pkg::*;

   // disabled channels report zero values
   `PSCU_ASSERT_IMP(a_temp_off_zero, clock, reset, rsp_valid && !temp_valid, temp_centi == '0, "temperature value set on disabled channel")
   `PSCU_ASSERT_IMP(a_press_off_zero, clock, reset, rsp_valid && (press_status != PRESS_OK), press_q8 == '0, "pressure value set with non-ok status")
   // humidity stays clamped, and zero when disabled
   `PSCU_ASSERT_IMP(a_hum_range, clock, reset, rsp_valid, (hum_q10 <= HUM_Q10_MAX) && (hum_valid || (hum_q10 == '0)), "humidity out of range")
   // status is one of the defined codes
   `PSCU_ASSERT_IMP(a_press_code, clock, reset, rsp_valid, (press_status == PRESS_OK) || (press_status == PRESS_DISABLED) || (press_status == PRESS_ZERO_DIV), "undefined pressure status")
   // a stalled result stays valid, with its pressure and humidity held
   `PSCU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(press_q8) && $stable(hum_q10), "stalled result changed")

endmodule

bind pth_sensor_compensation_unit pscu_checker u_pscu_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .temp_centi(rsp_bus.temp_centi),
   .temp_valid(rsp_bus.temp_valid),
   .press_q8(rsp_bus.press_q8),
   .press_status(rsp_bus.press_status),
   .hum_q10(rsp_bus.hum_q10),
   .hum_valid(rsp_bus.hum_valid)
);

FILE: tb/tb_pth_sensor_compensation_unit.sv
// Self-checking testbench of the sensor compensation unit: drives raw sample sets and
// calibration writes, predicts every compensated result and checks it field by field.
// Depends on pscu_pkg, pscu_ifs and the pth_sensor_compensation_unit RTL.
module tb_pth_sensor_compensation_unit;
   import pscu_pkg::*;

   typedef struct {
      logic signed [15:0] temp_centi;
      logic               temp_valid;
      logic [31:0]        press_q8;
      logic [1:0]         press_status;
      logic [16:0]        hum_q10;
      logic               hum_valid;
   } comp_result_type;

   localparam int DRAIN_CYCLES = 1600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   pscu_req_if req_bus ();
   pscu_rsp_if rsp_bus ();

   pth_sensor_compensation_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state: calibration copy and fine temperature
   logic [63:0]     cal_regs [6];
   longint          fine_temp;
   comp_result_type pending_results[$];
   int              error_count = 0;
   int              sent_count = 0;
   int              checked_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_cycles = 0;

   function automatic longint t32(longint x);
      return longint'($signed(x[31:0]));
   endfunction

   function automatic comp_result_type compensate(logic [23:0] rt, logic [23:0] rp,
                                                  logic [15:0] rh);
      comp_result_type r;
      longint t1, t2, t3, adc, ta, tb, tf, tc, off;
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, num;
      longint h1, h2, h3, h4, h5, h6, hv, ha, hb, hc;
      r = '{default: '0};
      // temperature and fine temperature
      if (rt != DISABLED_24) begin
         t1 = longint'(cal_regs[0][15:0]);
         t2 = longint'($signed(cal_regs[0][31:16]));
         t3 = longint'($signed(cal_regs[0][47:32]));
         off = longint'($signed(cal_regs[5][20:0]));
         adc = longint'(rt[23:4]);
         ta = ((adc >>> 3) - 2 * t1) * t2;
         tb = (adc >>> 4) - t1;
         tf = (ta >>> 11) + ((((tb * tb) >>> 12) * t3) >>> 14) + off;
         fine_temp = t32(tf);
         tc = (fine_temp * 5 + 128) >>> 8;
         if (tc > 32767) tc = 32767;
         if (tc < -32768) tc = -32768;
         r.temp_centi = tc[15:0];
         r.temp_valid = 1'b1;
      end
      // pressure
      if (rp == DISABLED_24) begin
         r.press_status = PRESS_DISABLED;
      end else begin
         p1 = longint'(cal_regs[1][15:0]);
         p2 = longint'($signed(cal_regs[1][31:16]));
         p3 = longint'($signed(cal_regs[1][47:32]));
         p4 = longint'($signed(cal_regs[1][63:48]));
         p5 = longint'($signed(cal_regs[2][15:0]));
         p6 = longint'($signed(cal_regs[2][31:16]));
         p7 = longint'($signed(cal_regs[2][47:32]));
         p8 = longint'($signed(cal_regs[2][63:48]));
         p9 = longint'($signed(cal_regs[3][15:0]));
         v1 = fine_temp - 128000;
         v2 = v1 * v1 * p6;
         v2 = v2 + ((v1 * p5) <<< 17);
         v2 = v2 + (p4 <<< 35);
         v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
         v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
         if (v1 == 0) begin
            r.press_status = PRESS_ZERO_DIV;
         end else begin
            p = 1048576 - longint'(rp[23:4]);
            num = ((p <<< 31) - v2) * 3125;
            if (num == 64'sh8000_0000_0000_0000 && v1 == -1) p = num;
            else p = num / v1;
            v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            r.press_status = PRESS_OK;
            if (p < 0) r.press_q8 = '0;
            else if (p > 64'sh0_FFFF_FFFF) r.press_q8 = '1;
            else r.press_q8 = p[31:0];
         end
      end
      // humidity, 32-bit wrapping arithmetic
      if (rh != DISABLED_16) begin
         h1 = longint'(cal_regs[3][23:16]);
         h2 = longint'($signed(cal_regs[3][39:24]));
         h3 = longint'(cal_regs[3][47:40]);
         h4 = longint'($signed(cal_regs[4][11:0]));
         h5 = longint'($signed(cal_regs[4][23:12]));
         h6 = longint'($signed(cal_regs[4][31:24]));
         hv = t32(fine_temp - 76800);
         ha = t32(longint'(rh) * 16384);
         ha = t32(ha - h4 * 1048576);
         ha = t32(ha - t32(h5 * hv));
         ha = t32(ha + 16384) >>> 15;
         hb = t32(hv * h6) >>> 10;
         hc = t32((t32(hv * h3) >>> 11) + 32768);
         hb = t32(hb * hc) >>> 10;
         hb = t32(hb + 2097152);
         hb = t32(t32(hb * h2) + 8192) >>> 14;
         hv = t32(ha * hb);
         hc = hv >>> 15;
         hc = t32(hc * hc) >>> 7;
         hc = t32(hc * h1) >>> 4;
         hv = t32(hv - hc);
         if (hv < 0) hv = 0;
         if (hv > 419430400) hv = 419430400;
         hv = hv >>> 12;
         r.hum_q10 = hv[16:0];
         r.hum_valid = 1'b1;
      end
      return r;
   endfunction

   // calibration write, only while the block is idle
   task automatic write_csr(pscu_csr_type idx, logic [63:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_CAL_TEMPERATURE, CSR_CAL_PRESS_HUM: cal_regs[idx] = {16'h0, data[47:0]};
         CSR_CAL_HUMIDITY:                       cal_regs[idx] = {32'h0, data[31:0]};
         CSR_FINE_TEMP_OFFSET:                   cal_regs[idx] = {43'h0, data[20:0]};
         default:                                cal_regs[idx] = data;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_all(logic [63:0] ct, logic [63:0] pl, logic [63:0] phi,
                            logic [63:0] ph, logic [63:0] hu, logic [63:0] off);
      write_csr(CSR_CAL_TEMPERATURE, ct);
      write_csr(CSR_CAL_PRESSURE_LOW, pl);
      write_csr(CSR_CAL_PRESSURE_HIGH, phi);
      write_csr(CSR_CAL_PRESS_HUM, ph);
      write_csr(CSR_CAL_HUMIDITY, hu);
      write_csr(CSR_FINE_TEMP_OFFSET, off);
   endtask

   // typical factory coefficients, with the offset given
   task automatic write_typical(logic [20:0] off);
      write_all({16'hFC18, 16'd26435, 16'd27504},
                {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                {8'd0, 16'd362, 8'd75, 16'd6000},
                {8'd30, 12'd50, 12'd313}, {43'h0, off});
   endtask

   // one sample set transfer, then its prediction
   task automatic send_sample(logic [23:0] rt, logic [23:0] rp, logic [15:0] rh);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.raw_temperature = rt;
      req_bus.raw_pressure = rp;
      req_bus.raw_humidity = rh;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(compensate(rt, rp, rh));
      sent_count++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [23:0] live_word(int lo, int hi);
      logic [19:0] adc;
      adc = 20'($urandom_range(hi, lo));
      return {adc, 4'($urandom)};
   endfunction

   // realistic words mostly, full-range noise and disabled codes otherwise
   task automatic send_random_sample();
      logic [23:0] rt, rp;
      logic [15:0] rh;
      int k;
      k = $urandom_range(99);
      rt = (k < 70) ? live_word(400000, 650000) : 24'($urandom);
      rp = (k < 70) ? live_word(250000, 450000) : 24'($urandom);
      rh = (k < 70) ? 16'($urandom_range(40000, 20000)) : 16'($urandom);
      if ($urandom_range(99) < 8) rt = DISABLED_24;
      if ($urandom_range(99) < 8) rp = DISABLED_24;
      if ($urandom_range(99) < 8) rh = DISABLED_16;
      send_sample(rt, rp, rh);
   endtask

   // all-zero calibration: every pressure hits the zero-divisor guard
   task automatic test_reset_calibration();
      send_sample(24'h7F0000, 24'h5A0000, 16'h6000);
      send_sample(24'h000000, 24'hFFFFFF, 16'h0000);
      wait_drained();
   endtask

   // field extremes and disabled channels with typical coefficients
   task automatic test_field_extremes();
      write_typical(21'h0);
      send_sample(24'h7EED00, 24'h655A00, 16'h6A7F);
      send_sample(24'h000000, 24'h000000, 16'h0000);
      send_sample(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
      send_sample(24'h80000F, 24'h800001, 16'h8001);
      send_sample(DISABLED_24, 24'h655A00, 16'h6A7F);
      send_sample(24'h7EED00, DISABLED_24, 16'h6A7F);
      send_sample(24'h7EED00, 24'h655A00, DISABLED_16);
      send_sample(DISABLED_24, DISABLED_24, DISABLED_16);
      send_sample(24'hAAAAAA, 24'h555555, 16'hAAAA);
      send_sample(24'h555555, 24'hAAAAAA, 16'h5555);
      wait_drained();
      // the largest and the most negative fine temperature offsets shift the temperature both ways
      write_csr(CSR_FINE_TEMP_OFFSET, 64'h0F_FFFF);
      send_sample(24'h7EED00, 24'h655A00, 16'h6A7F);
      send_sample(DISABLED_24, 24'h300000, 16'h9000);
      wait_drained();
      write_csr(CSR_FINE_TEMP_OFFSET, 64'h10_0000);
      send_sample(24'h7EED00, 24'h655A00, 16'h6A7F);
      send_sample(24'hFFFFF0, 24'h000010, 16'hFFFF);
      wait_drained();
   endtask

   // all-ones, then signed-extreme calibration words: wrapping arithmetic
   task automatic test_extreme_calibration();
      write_all('1, '1, '1, '1, '1, '1);
      send_sample(24'h7EED00, 24'h655A00, 16'h6A7F);
      send_sample(24'hFFFFFF, 24'h000000, 16'hFFFF);
      wait_drained();
      write_all({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
                {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, {8'hFF, 16'h8000, 8'hFF, 16'h7FFF},
                {8'h80, 12'h800, 12'h7FF}, 64'h0);
      send_sample(24'h000000, 24'h7FFFF0, 16'h0001);
      send_sample(24'hFFFFFF, 24'hFFFFFF, 16'h7FFF);
      wait_drained();
   endtask

   // receiver holds off long enough for the block to fill and stall its input
   task automatic test_output_stall();
      write_typical(21'h000400);
      hold_cycles = 4000;
      repeat (4) send_random_sample();
      wait_drained();
   endtask

   // random sample sets under one idling pattern and a random calibration
   task automatic test_random_phase(int n, int sidle, int ridle);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      if ($urandom_range(1)) write_typical(21'($urandom_range(8000) - 4000));
      else write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {32'h0, $urandom}, {32'h0, $urandom});
      repeat (n) send_random_sample();
      wait_drained();
   endtask

   // receiver: random ready, with a counted hold-off on request
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      comp_result_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no sample set outstanding");
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            checked_count++;
            if (rsp_bus.temp_centi !== exp_r.temp_centi) begin
               $error("temp_centi exp %0d got %0d", exp_r.temp_centi, rsp_bus.temp_centi);
               error_count++;
            end
            if (rsp_bus.temp_valid !== exp_r.temp_valid) begin
               $error("temp_valid exp %0b got %0b", exp_r.temp_valid, rsp_bus.temp_valid);
               error_count++;
            end
            if (rsp_bus.press_q8 !== exp_r.press_q8) begin
               $error("press_q8 exp %0h got %0h", exp_r.press_q8, rsp_bus.press_q8);
               error_count++;
            end
            if (rsp_bus.press_status !== exp_r.press_status) begin
               $error("press_status exp %0d got %0d", exp_r.press_status,
                      rsp_bus.press_status);
               error_count++;
            end
            if (rsp_bus.hum_q10 !== exp_r.hum_q10) begin
               $error("hum_q10 exp %0d got %0d", exp_r.hum_q10, rsp_bus.hum_q10);
               error_count++;
            end
            if (rsp_bus.hum_valid !== exp_r.hum_valid) begin
               $error("hum_valid exp %0b got %0b", exp_r.hum_valid, rsp_bus.hum_valid);
               error_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < 6; i++) cal_regs[i] = '0;
      fine_temp = 0;
      req_bus.valid = 1'b0;
      req_bus.raw_temperature = '0;
      req_bus.raw_pressure = '0;
      req_bus.raw_humidity = '0;
      rsp_bus.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_calibration();
      test_field_extremes();
      test_extreme_calibration();
      test_output_stall();
      test_random_phase(150, 29, 85);
      test_random_phase(150, 85, 29);
      test_random_phase(150, 0, 0);

      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         error_count++;
      end
      $display("covered %0d sample sets, %0d results checked, over several calibrations",
               sent_count, checked_count);
      if (error_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog
   initial begin
      #(8 * 8_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: pth_sensor_compensation_unit.f
+incdir+src
src/pscu_pkg.sv
src/pscu_ifs.sv
src/pscu_mul.sv
src/pscu_div.sv
src/pth_sensor_compensation_unit.sv
src/pscu_checker.sv
tb/tb_pth_sensor_compensation_unit.sv
